FILE: hw/rtl/preprocessor_directive_scanner_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the directive scanner
// Shared forms for concurrent checks, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef PREPROCESSOR_DIRECTIVE_SCANNER_CORE_MACROS_SVH
`define PREPROCESSOR_DIRECTIVE_SCANNER_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PDS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define PDS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

FILE: hw/rtl/pds_pkg.sv
// ----------------------------------------------------------------------------
// Directive scanner package
// Word types, byte classes, directive kinds and the keyword classifier.
// ----------------------------------------------------------------------------
package pds_pkg;

	localparam int KEY_MAX = 8;
	localparam int LEN_W   = 16;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_of_token;
		logic       at_end;
	} in_word_t;

	typedef struct packed {
		logic [1:0]       directive_kind;
		logic [LEN_W-1:0] token_length;
		logic             byte_taken;
	} out_word_t;

	typedef enum logic [2:0] {
		CLS_LF,
		CLS_CR,
		CLS_BLANK,
		CLS_LETTER,
		CLS_OTHER
	} byte_cls_t;

	// Word handed from the front to the back through the queue.
	typedef struct packed {
		logic [7:0] data_byte;
		byte_cls_t  cls;
		logic       start_of_token;
		logic       at_end;
	} item_t;

	localparam logic [1:0] KIND_OTHER = 2'd0;
	localparam logic [1:0] KIND_IF    = 2'd1;
	localparam logic [1:0] KIND_ELSE  = 2'd2;
	localparam logic [1:0] KIND_ENDIF = 2'd3;

	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;

	function automatic byte_cls_t classify_byte(logic [7:0] c);
		byte_cls_t cls;
		if (c == CH_LF)
			cls = CLS_LF;
		else if (c == CH_CR)
			cls = CLS_CR;
		else if (c == CH_SP || c == CH_TAB)
			cls = CLS_BLANK;
		else if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A))
			cls = CLS_LETTER;
		else
			cls = CLS_OTHER;
		return cls;
	endfunction

	// Letters are shifted in at the low end, so the last count bytes read like
	// a string literal with the first letter at the top.
	function automatic logic [1:0] classify_keyword(logic [8*KEY_MAX-1:0] letters,
			logic [3:0] count);
		logic [1:0] kind;
		kind = KIND_OTHER;
		case (count)
			4'd2: begin
				if (letters[15:0] == "if")
					kind = KIND_IF;
			end
			4'd4: begin
				if (letters[31:0] == "elif" || letters[31:0] == "else")
					kind = KIND_ELSE;
			end
			4'd5: begin
				if (letters[39:0] == "ifdef")
					kind = KIND_IF;
				else if (letters[39:0] == "endif")
					kind = KIND_ENDIF;
			end
			4'd6: begin
				if (letters[47:0] == "ifndef")
					kind = KIND_IF;
			end
			4'd7: begin
				if (letters[55:0] == "elifdef")
					kind = KIND_ELSE;
			end
			4'd8: begin
				if (letters[63:0] == "elifndef")
					kind = KIND_ELSE;
			end
			default: kind = KIND_OTHER;
		endcase
		return kind;
	endfunction

endpackage

FILE: hw/rtl/pds_fifo.sv
// ----------------------------------------------------------------------------
// Directive scanner queue
// Small register queue with a count; head word is shown while not empty.
// ----------------------------------------------------------------------------
module pds_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

FILE: hw/rtl/pds_front.sv
// ----------------------------------------------------------------------------
// Directive scanner front end
// Accepts input words, classifies each byte and queues it for the back end.
// ----------------------------------------------------------------------------
module pds_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  pds_pkg::in_word_t item,
	output logic              full,
	input  logic              take,
	output pds_pkg::item_t    head,
	output logic              head_empty
);
	import pds_pkg::*;

	localparam int QUEUE_DEPTH = 4;

	item_t                cls_item;
	logic [$bits(item_t)-1:0] head_bits;

	always_comb begin
		cls_item.data_byte      = item.data_byte;
		cls_item.cls            = classify_byte(item.data_byte);
		cls_item.start_of_token = item.start_of_token;
		cls_item.at_end         = item.at_end;
	end

	pds_fifo #(
		.WIDTH($bits(item_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (cls_item),
		.full  (full),
		.pop   (take),
		.rdata (head_bits),
		.empty (head_empty)
	);

	assign head = item_t'(head_bits);

endmodule

FILE: hw/rtl/pds_back.sv
// ----------------------------------------------------------------------------
// Directive scanner back end
// Runs the scan state machine on classified bytes and queues the results.
// ----------------------------------------------------------------------------
module pds_back #(
	parameter int LENGTH_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pds_pkg::item_t     head,
	input  logic               head_empty,
	output logic               take,
	output logic               empty,
	input  logic               pop,
	output pds_pkg::out_word_t result
);
	import pds_pkg::*;

	localparam int RES_DEPTH = 2;

	localparam logic [2:0] PH_IDLE     = 3'd0;
	localparam logic [2:0] PH_BLANKS   = 3'd1;
	localparam logic [2:0] PH_KEYWORD  = 3'd2;
	localparam logic [2:0] PH_REST     = 3'd3;
	localparam logic [2:0] PH_AFTER_CR = 3'd4;

	logic [2:0]             phase_q;
	logic [2:0]             phase_d;
	logic [8*KEY_MAX-1:0]   letters_q;
	logic [3:0]             kcount_q;
	logic [3:0]             kcount_d;
	logic                   shift_letter;
	logic [LENGTH_BITS-1:0] bcount_q;
	logic [LENGTH_BITS-1:0] bcount_d;
	logic [LENGTH_BITS-1:0] bcount_inc;
	logic                   emit;
	logic                   taken;
	logic                   emit_inc;
	logic [LENGTH_BITS-1:0] emit_count;
	logic [LENGTH_BITS+LEN_W-1:0] emit_ext;
	out_word_t              res_word;
	logic                   res_full;
	logic [$bits(out_word_t)-1:0] res_bits;

	assign take       = !head_empty && !res_full;
	assign bcount_inc = (bcount_q == '1) ? bcount_q : bcount_q + 1'b1;

	always_comb begin
		phase_d      = phase_q;
		kcount_d     = kcount_q;
		bcount_d     = bcount_q;
		shift_letter = 1'b0;
		emit         = 1'b0;
		taken        = 1'b0;
		emit_inc     = 1'b0;
		unique case (phase_q) inside
			PH_IDLE: begin
				if (head.start_of_token && !head.at_end) begin
					phase_d  = PH_BLANKS;
					kcount_d = '0;
					bcount_d = LENGTH_BITS'(1);
				end
			end
			PH_AFTER_CR: begin
				emit    = 1'b1;
				phase_d = PH_IDLE;
				if (head.at_end) begin
					taken = 1'b0;
				end else if (head.cls == CLS_LF) begin
					taken    = 1'b1;
					emit_inc = 1'b1;
					bcount_d = bcount_inc;
				end else if (head.start_of_token) begin
					// The byte after a lone CR may open the next directive.
					phase_d  = PH_BLANKS;
					kcount_d = '0;
					bcount_d = LENGTH_BITS'(1);
				end
			end
			PH_BLANKS, PH_KEYWORD, PH_REST: begin
				if (head.at_end) begin
					emit    = 1'b1;
					phase_d = PH_IDLE;
				end else begin
					bcount_d = bcount_inc;
					if (head.cls == CLS_LF) begin
						emit     = 1'b1;
						taken    = 1'b1;
						emit_inc = 1'b1;
						phase_d  = PH_IDLE;
					end else if (head.cls == CLS_CR) begin
						phase_d = PH_AFTER_CR;
					end else if (phase_q == PH_BLANKS) begin
						if (head.cls == CLS_LETTER) begin
							shift_letter = 1'b1;
							kcount_d     = 4'd1;
							phase_d      = PH_KEYWORD;
						end else if (head.cls != CLS_BLANK) begin
							phase_d = PH_REST;
						end
					end else if (phase_q == PH_KEYWORD) begin
						if (head.cls == CLS_LETTER && kcount_q < 4'(KEY_MAX)) begin
							shift_letter = 1'b1;
							kcount_d     = kcount_q + 1'b1;
						end else begin
							phase_d = PH_REST;
						end
					end
				end
			end
			default: phase_d = PH_IDLE;
		endcase
	end

	// The reported length saturates at the width of the length field.
	assign emit_count = emit_inc ? bcount_inc : bcount_q;
	assign emit_ext   = {{LEN_W{1'b0}}, emit_count};

	always_comb begin
		res_word.directive_kind = classify_keyword(letters_q, kcount_q);
		res_word.token_length   = (|emit_ext[LENGTH_BITS+LEN_W-1:LEN_W]) ?
			{LEN_W{1'b1}} : emit_ext[LEN_W-1:0];
		res_word.byte_taken     = taken;
	end

	always_ff @(posedge clk) begin
		if (take && shift_letter)
			letters_q <= {letters_q[8*KEY_MAX-9:0], head.data_byte};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			kcount_q <= '0;
			bcount_q <= '0;
		end else if (take) begin
			phase_q  <= phase_d;
			kcount_q <= kcount_d;
			bcount_q <= bcount_d;
		end
	end

	pds_fifo #(
		.WIDTH($bits(out_word_t)),
		.DEPTH(RES_DEPTH)
	) u_results (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (take && emit),
		.wdata (res_word),
		.full  (res_full),
		.pop   (pop),
		.rdata (res_bits),
		.empty (empty)
	);

	assign result = out_word_t'(res_bits);

endmodule

FILE: hw/rtl/preprocessor_directive_scanner_core.sv
// ----------------------------------------------------------------------------
// Preprocessor directive scanner
// Scans a directive line from its start-marked byte; reports kind and length.
// ----------------------------------------------------------------------------
// One byte word is accepted per clock cycle while the classified queue has
// room. A pushed word enters a four-entry classified queue; the scan state
// machine takes one word from it each cycle while the result queue has room
// and writes at most one result word into a two-entry result queue. A result
// is registered there as the ending byte leaves the classified queue. The scan
// state update (phase, keyword letters, saturating byte count) sets the rate.
module preprocessor_directive_scanner_core #(
	parameter int LENGTH_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  pds_pkg::in_word_t  item,
	output logic               empty,
	input  logic               pop,
	output pds_pkg::out_word_t result
);
	import pds_pkg::*;

	item_t head;
	logic  head_empty;
	logic  take;

	pds_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.item      (item),
		.full      (full),
		.take      (take),
		.head      (head),
		.head_empty(head_empty)
	);

	pds_back #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.head_empty(head_empty),
		.take      (take),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule

FILE: hw/rtl/pds_checker.sv
// ----------------------------------------------------------------------------
// Directive scanner port checker
// Watches the top-level ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
`include "preprocessor_directive_scanner_core_macros.svh"

module pds_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               push,
	input logic               full,
	input logic               empty,
	input logic               pop,
	input pds_pkg::out_word_t result
);
	import pds_pkg::*;

	// A waiting result word holds until it is popped.
	`PDS_ASSERT_NXT(a_result_hold, clk, arst_n, !empty && !pop, !empty && $stable(result))

	// The queue can only fill up after a word was pushed.
	`PDS_ASSERT_IMP(a_full_after_push, clk, arst_n, $rose(full), $past(push))

	// Every directive counts at least its opening byte.
	`PDS_ASSERT_IMP(a_length_nonzero, clk, arst_n, !empty, result.token_length != '0)

	// A recognized keyword needs the opening byte and at least two letters.
	`PDS_ASSERT_IMP(a_keyword_length, clk, arst_n,
		!empty && result.directive_kind != KIND_OTHER, result.token_length >= 16'd3)

endmodule

bind preprocessor_directive_scanner_core pds_checker u_pds_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.push  (push),
	.full  (full),
	.empty (empty),
	.pop   (pop),
	.result(result)
);

FILE: test/tb_preprocessor_directive_scanner_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Directive scanner testbench
// Feeds byte words that form directive lines, with blanks, keywords, tails,
// every kind of line end and noise between lines. A scoreboard follows the
// scan on every accepted byte word and compares each result word field by
// field, while both sides stall at random and the result side holds off once.
// ----------------------------------------------------------------------------
module tb_preprocessor_directive_scanner_core;
	import pds_pkg::*;

	localparam logic [7:0] HASH = 8'h23;
	localparam int HOLD_CYCLES  = 300;
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 20;

	typedef enum logic [2:0] {
		SCAN_IDLE,
		SCAN_BLANKS,
		SCAN_KEYWORD,
		SCAN_REST,
		SCAN_AFTER_CR
	} scan_phase_t;

	typedef enum int {
		END_LF,
		END_CRLF,
		END_CR,
		END_EOF,
		END_OPEN
	} line_end_t;

	typedef logic [7:0] byte_q_t [$];

	class directive_scoreboard;
		scan_phase_t      phase;
		logic [7:0]       kw_letters [KEY_MAX];
		int unsigned      kw_count;
		logic [LEN_W-1:0] line_bytes;
		out_word_t        pending_words [$];
		int unsigned      scanned;
		int unsigned      predicted;
		int unsigned      mismatches;

		function new();
			phase = SCAN_IDLE;
			kw_count = 0;
			line_bytes = '0;
			scanned = 0;
			predicted = 0;
			mismatches = 0;
		endfunction

		function bit is_letter(logic [7:0] c);
			logic [7:0] folded;
			// Setting bit 5 folds upper case onto lower case and moves nothing else
			// into the lower-case range.
			folded = c | 8'h20;
			return folded >= 8'h61 && folded <= 8'h7A;
		endfunction

		function bit keyword_is(string name);
			int i;
			if (name.len() != kw_count)
				return 1'b0;
			for (i = 0; i < name.len(); i++)
				if (kw_letters[i] != name.getc(i))
					return 1'b0;
			return 1'b1;
		endfunction

		function logic [1:0] keyword_kind();
			if (keyword_is("if") || keyword_is("ifdef") || keyword_is("ifndef"))
				return KIND_IF;
			if (keyword_is("elif") || keyword_is("elifdef") || keyword_is("elifndef") ||
					keyword_is("else"))
				return KIND_ELSE;
			if (keyword_is("endif"))
				return KIND_ENDIF;
			return KIND_OTHER;
		endfunction

		function void open_line();
			phase = SCAN_BLANKS;
			kw_count = 0;
			line_bytes = LEN_W'(1);
		endfunction

		function void count_byte();
			if (line_bytes != '1)
				line_bytes++;
		endfunction

		function void close_line(logic taken);
			out_word_t w;
			w.directive_kind = keyword_kind();
			w.token_length = line_bytes;
			w.byte_taken = taken;
			pending_words.push_back(w);
			predicted++;
			phase = SCAN_IDLE;
		endfunction

		// Notes one accepted byte word and queues the result word it causes.
		function void take_byte(in_word_t w);
			logic [7:0] c;
			c = w.data_byte;
			if (phase != SCAN_IDLE || w.start_of_token)
				scanned++;
			if (phase == SCAN_IDLE) begin
				if (w.start_of_token && !w.at_end)
					open_line();
			end else if (w.at_end) begin
				close_line(1'b0);
			end else if (phase == SCAN_AFTER_CR) begin
				if (c == CH_LF) begin
					count_byte();
					close_line(1'b1);
				end else begin
					// A lone CR ends the line; this byte stays outside it but may open
					// the next directive.
					close_line(1'b0);
					if (w.start_of_token)
						open_line();
				end
			end else begin
				count_byte();
				if (c == CH_LF) begin
					close_line(1'b1);
				end else if (c == CH_CR) begin
					phase = SCAN_AFTER_CR;
				end else if (phase == SCAN_BLANKS) begin
					if (c != CH_SP && c != CH_TAB) begin
						if (is_letter(c)) begin
							kw_letters[0] = c;
							kw_count = 1;
							phase = SCAN_KEYWORD;
						end else begin
							phase = SCAN_REST;
						end
					end
				end else if (phase == SCAN_KEYWORD) begin
					if (is_letter(c) && kw_count < KEY_MAX) begin
						kw_letters[kw_count] = c;
						kw_count++;
					end else begin
						phase = SCAN_REST;
					end
				end
			end
		endfunction

		function void check_word(out_word_t got);
			out_word_t want;
			if (pending_words.size() == 0) begin
				mismatches++;
				$display("%0t: result word with none expected: kind %0d length %0d taken %0b",
					$time, got.directive_kind, got.token_length, got.byte_taken);
				return;
			end
			want = pending_words.pop_front();
			if (got.directive_kind !== want.directive_kind ||
					got.token_length !== want.token_length ||
					got.byte_taken !== want.byte_taken) begin
				mismatches++;
				$display({"%0t: expected kind %0d length %0d taken %0b,",
					" got kind %0d length %0d taken %0b"},
					$time, want.directive_kind, want.token_length, want.byte_taken,
					got.directive_kind, got.token_length, got.byte_taken);
			end
		endfunction
	endclass

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      push = 1'b0;
	logic      full;
	in_word_t  item = '0;
	logic      empty;
	logic      pop = 1'b0;
	out_word_t result;

	directive_scoreboard sb;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_req = 1'b0;
	int stall_cycles = 0;

	preprocessor_directive_scanner_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full)
				sb.take_byte(item);
			if (pop && !empty)
				sb.check_word(result);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("preprocessor_directive_scanner_core verification failed");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	initial begin : receiver
		bit hold_done;
		hold_done = 1'b0;
		@(posedge clk);
		forever begin
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			pop <= ($urandom_range(99) >= recv_idle_pct);
			@(posedge clk);
		end
	end

	task automatic send_word(input logic [7:0] data, input logic sot, input logic fin);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= '{data_byte: data, start_of_token: sot, at_end: fin};
		@(posedge clk);
		while (full)
			@(posedge clk);
	endtask

	task automatic send_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			send_word(s.getc(i), 1'b0, 1'b0);
	endtask

	function automatic logic [7:0] text_byte();
		logic [7:0] c;
		do
			c = 8'($urandom_range(255));
		while (c == CH_LF || c == CH_CR);
		return c;
	endfunction

	function automatic logic [7:0] rand_letter();
		return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'($urandom_range(25));
	endfunction

	function automatic logic stray_mark();
		return $urandom_range(9) == 0;
	endfunction

	function automatic byte_q_t pick_keyword();
		string names [14] = '{"if", "ifdef", "ifndef", "elif", "elifdef", "elifndef", "else",
			"endif", "define", "include", "IF", "Endif", "elifndefx", "elsewhere"};
		byte_q_t kw;
		string s;
		int i;
		int r;
		r = $urandom_range(9);
		if (r <= 6) begin
			s = names[$urandom_range(13)];
			for (i = 0; i < s.len(); i++)
				kw.push_back(s.getc(i));
		end else if (r <= 8) begin
			repeat ($urandom_range(12, 1))
				kw.push_back(rand_letter());
		end
		return kw;
	endfunction

	task automatic send_directive(input byte_q_t kw, input int tail_len, input line_end_t ending);
		int i;
		send_word(($urandom_range(3) == 0) ? 8'($urandom_range(255)) : HASH, 1'b1, 1'b0);
		repeat ($urandom_range(2))
			send_word($urandom_range(1) ? CH_SP : CH_TAB, stray_mark(), 1'b0);
		for (i = 0; i < kw.size(); i++)
			send_word(kw[i], stray_mark(), 1'b0);
		for (i = 0; i < tail_len; i++)
			send_word((i == 0 && $urandom_range(1)) ? CH_SP : text_byte(), stray_mark(), 1'b0);
		case (ending)
			END_LF: send_word(CH_LF, stray_mark(), 1'b0);
			END_CRLF: begin
				send_word(CH_CR, stray_mark(), 1'b0);
				send_word(CH_LF, stray_mark(), 1'b0);
			end
			END_CR: send_word(CH_CR, stray_mark(), 1'b0);
			END_EOF: send_word(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
			default: ;
		endcase
	endtask

	task automatic random_line();
		int r;
		line_end_t ending;
		int tail_len;
		r = $urandom_range(9);
		if (r <= 3)
			ending = END_LF;
		else if (r <= 5)
			ending = END_CRLF;
		else if (r <= 7)
			ending = END_CR;
		else if (r == 8)
			ending = END_EOF;
		else
			ending = END_OPEN;
		tail_len = ($urandom_range(7) == 0) ? $urandom_range(30) : $urandom_range(4);
		send_directive(pick_keyword(), tail_len, ending);
	endtask

	task automatic random_stream(input int unsigned word_goal, input int unsigned result_goal);
		int unsigned base_words;
		int unsigned base_results;
		base_words = sb.scanned;
		base_results = sb.predicted;
		while (sb.scanned - base_words < word_goal || sb.predicted - base_results < result_goal) begin
			if ($urandom_range(6) == 0)
				send_word(8'($urandom_range(255)), 1'b0, $urandom_range(3) == 0);
			else
				random_line();
		end
	endtask

	initial begin : stimulus
		byte_q_t short_kw;
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 23;
		recv_idle_pct = 72;

		// While idle, a stray byte and an end marker change nothing.
		send_word(8'hFF, 1'b0, 1'b0);
		send_word(8'h00, 1'b1, 1'b1);
		// The marked byte opens the line whatever its value.
		send_word(8'h00, 1'b1, 1'b0);
		send_text("if");
		send_word(CH_LF, 1'b0, 1'b0);
		send_word(HASH, 1'b1, 1'b0);
		send_text("endif");
		send_word(CH_CR, 1'b0, 1'b0);
		send_word(CH_LF, 1'b0, 1'b0);
		// A lone CR: the marked byte after it is left out and opens the next line.
		send_word(HASH, 1'b1, 1'b0);
		send_word(CH_TAB, 1'b0, 1'b0);
		send_text("else");
		send_word(CH_CR, 1'b0, 1'b0);
		send_word(HASH, 1'b1, 1'b0);
		// A mark inside a line is plain text; the end marker cuts the line short.
		send_word(8'h78, 1'b1, 1'b0);
		send_word(8'hFF, 1'b0, 1'b1);

		random_stream(80, 8);

		send_idle_pct = 72;
		recv_idle_pct = 23;
		random_stream(80, 8);

		send_idle_pct = 0;
		recv_idle_pct = 0;

		// Short lines while the result side holds off, so the input backs up.
		short_kw = '{8'h69, 8'h66};
		hold_req = 1'b1;
		repeat (30)
			send_directive(short_kw, 0, END_LF);

		random_stream(60, 6);
		push <= 1'b0;

		while (sb.pending_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.mismatches == 0 && sb.pending_words.size() == 0)
			$display("preprocessor_directive_scanner_core verification clean");
		else
			$display("preprocessor_directive_scanner_core verification failed");
		$finish;
	end

endmodule
